// ----- rtl/core/roi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package roi_pkg;

    // Fraction bits of every coordinate and matrix component
    localparam int COORD_FRAC_BITS = 8;
    // Fraction bits of the distance
    localparam int Q_FRAC = 16;

    localparam int CFG_W = 48;
    localparam int CFG_IDX_W = 2;

    // Numerator magnitude, divisor and divider widths
    localparam int NUM_W = 36;
    localparam int DEN_W = 33;
    localparam int DIV_BITS = NUM_W + Q_FRAC;
    localparam int DIV_LAT = DIV_BITS + 1;
    // Signed slab parameter width
    localparam int T_W = DIV_BITS + 2;

    localparam logic [CFG_W-1:0] RIGHT_RESET = 48'h0000_0100_0000;
    localparam logic [CFG_W-1:0] UP_RESET = 48'h0000_0000_0100;
    localparam logic [CFG_W-1:0] LOOK_RESET = 48'h0000_0000_0001;
    localparam logic [CFG_W-1:0] POS_RESET = 48'h0000_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RIGHT = 2'd0,
        CFG_UP = 2'd1,
        CFG_LOOK = 2'd2,
        CFG_POS = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic signed [15:0] ray_origin_x;
        logic signed [15:0] ray_origin_y;
        logic signed [15:0] ray_origin_z;
        logic signed [15:0] ray_dir_x;
        logic signed [15:0] ray_dir_y;
        logic signed [15:0] ray_dir_z;
    } roi_in_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] hit_distance;
    } roi_out_t;

    typedef struct packed {
        logic [CFG_W-1:0] right;
        logic [CFG_W-1:0] up;
        logic [CFG_W-1:0] look;
        logic [CFG_W-1:0] pos;
    } roi_cfg_t;

    // Per-axis slab terms handed from the front end to the dividers
    typedef struct packed {
        logic [NUM_W-1:0] num1;
        logic             neg1;
        logic [NUM_W-1:0] num2;
        logic             neg2;
        logic [DEN_W-1:0] den;
        logic [63:0]      sq;
        logic [31:0]      s;
        logic             fail;
    } roi_axis_t;

    // Per-axis flags riding beside the dividers
    typedef struct packed {
        logic [2:0] use_t;
        logic [2:0] ok;
    } roi_side_t;

endpackage

`default_nettype wire

// ----- rtl/core/roi_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module roi_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire roi_pkg::roi_in_t          in_item,
    input  wire roi_pkg::roi_cfg_t         cfg,
    output logic                           out_valid,
    output roi_pkg::roi_axis_t [2:0]       axis
);
    import roi_pkg::*;

    logic [CFG_W-1:0] rows [3];
    logic signed [15:0] pos_c [3];
    logic signed [15:0] org_c [3];
    logic signed [15:0] dir_c [3];

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [16:0] p_reg [3];
    logic signed [15:0] d_reg [3];
    logic signed [32:0] rpp_reg [3][3];
    logic signed [31:0] rdp_reg [3][3];
    logic signed [34:0] rp_reg [3];
    logic signed [33:0] rd_reg [3];
    logic [30:0] sqp_reg [3][3];
    logic [31:0] s_reg [3];
    roi_axis_t [2:0] axis_reg;

    logic signed [15:0] r_c [3][3];
    logic signed [31:0] rr [3][3];
    roi_axis_t [2:0] axis_next;

    logic signed [33:0] ard_full [3];
    logic [31:0] ard [3];
    logic signed [36:0] rp2 [3];
    logic signed [36:0] s37 [3];
    logic signed [36:0] n1 [3];
    logic signed [36:0] n2 [3];
    logic [36:0] m1 [3];
    logic [36:0] m2 [3];
    logic [34:0] arp [3];

    assign rows[0] = cfg.right;
    assign rows[1] = cfg.up;
    assign rows[2] = cfg.look;

    assign org_c[0] = in_item.ray_origin_x;
    assign org_c[1] = in_item.ray_origin_y;
    assign org_c[2] = in_item.ray_origin_z;
    assign dir_c[0] = in_item.ray_dir_x;
    assign dir_c[1] = in_item.ray_dir_y;
    assign dir_c[2] = in_item.ray_dir_z;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pos_c[k] = $signed(cfg.pos[16*k +: 16]);
            for (int i = 0; i < 3; i++)
            begin
                r_c[i][k] = $signed(rows[i][16*k +: 16]);
                rr[i][k] = r_c[i][k] * r_c[i][k];
            end
        end
    end

    // Squared row lengths follow the registers and settle while the block idles
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sqp_reg[i][k] <= rr[i][k][30:0];
            end
            s_reg[i] <= 32'(sqp_reg[i][0]) + 32'(sqp_reg[i][1]) + 32'(sqp_reg[i][2]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ard_full[i] = rd_reg[i][33] ? -rd_reg[i] : rd_reg[i];
            ard[i] = ard_full[i][31:0];
            rp2[i] = {rp_reg[i][34], rp_reg[i], 1'b0};
            s37[i] = $signed({5'd0, s_reg[i]});
            n1[i] = rp2[i] + s37[i];
            n2[i] = rp2[i] - s37[i];
            m1[i] = n1[i][36] ? 37'(-n1[i]) : 37'(n1[i]);
            m2[i] = n2[i][36] ? 37'(-n2[i]) : 37'(n2[i]);
            arp[i] = rp_reg[i][34] ? 35'(-rp_reg[i]) : 35'(rp_reg[i]);
            axis_next[i].num1 = m1[i][NUM_W-1:0];
            axis_next[i].neg1 = n1[i][36] ^ rd_reg[i][33];
            axis_next[i].num2 = m2[i][NUM_W-1:0];
            axis_next[i].neg2 = n2[i][36] ^ rd_reg[i][33];
            axis_next[i].den = {ard[i], 1'b0};
            axis_next[i].sq = 64'(ard[i]) * 64'(ard[i]);
            axis_next[i].s = s_reg[i];
            axis_next[i].fail = {arp[i], 1'b0} > {4'd0, s_reg[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p_reg[k] <= 17'(pos_c[k]) - 17'(org_c[k]);
                d_reg[k] <= dir_c[k];
            end
            for (int i = 0; i < 3; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    rpp_reg[i][k] <= r_c[i][k] * p_reg[k];
                    rdp_reg[i][k] <= r_c[i][k] * d_reg[k];
                end
                rp_reg[i] <= 35'(rpp_reg[i][0]) + 35'(rpp_reg[i][1]) + 35'(rpp_reg[i][2]);
                rd_reg[i] <= 34'(rdp_reg[i][0]) + 34'(rdp_reg[i][1]) + 34'(rdp_reg[i][2]);
            end
            axis_reg <= axis_next;
        end
    end

    assign out_valid = v4_reg;
    assign axis = axis_reg;

endmodule

`default_nettype wire

// ----- rtl/core/roi_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module roi_div (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic [roi_pkg::NUM_W-1:0]         num,
    input  wire logic                              neg,
    input  wire logic [roi_pkg::DEN_W-1:0]         den,
    output logic signed [roi_pkg::T_W-1:0]         quo
);
    import roi_pkg::*;

    logic [DEN_W-1:0] rem_reg [DIV_BITS];
    logic [DIV_BITS-1:0] num_reg [DIV_BITS];
    logic [DIV_BITS-1:0] quo_reg [DIV_BITS];
    logic [DEN_W-1:0] den_reg [DIV_BITS];
    logic neg_reg [DIV_BITS];
    logic signed [T_W-1:0] out_reg;

    logic [DEN_W-1:0] rem_in [DIV_BITS];
    logic [DIV_BITS-1:0] num_in [DIV_BITS];
    logic [DIV_BITS-1:0] quo_in [DIV_BITS];
    logic [DEN_W-1:0] den_in [DIV_BITS];
    logic neg_in [DIV_BITS];
    logic [DEN_W:0] cat [DIV_BITS];
    logic [DEN_W:0] diff [DIV_BITS];
    logic ge [DIV_BITS];

    logic [T_W-1:0] qext;
    logic signed [T_W-1:0] out_next;

    // One quotient bit per stage, restoring
    always_comb
    begin
        for (int k = 0; k < DIV_BITS; k++)
        begin
            if (k == 0)
            begin
                rem_in[k] = '0;
                num_in[k] = {num, {Q_FRAC{1'b0}}};
                quo_in[k] = '0;
                den_in[k] = den;
                neg_in[k] = neg;
            end
            else
            begin
                rem_in[k] = rem_reg[k-1];
                num_in[k] = num_reg[k-1];
                quo_in[k] = quo_reg[k-1];
                den_in[k] = den_reg[k-1];
                neg_in[k] = neg_reg[k-1];
            end
            cat[k] = {rem_in[k], num_in[k][DIV_BITS-1]};
            ge[k] = cat[k] >= {1'b0, den_in[k]};
            diff[k] = cat[k] - {1'b0, den_in[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_BITS; k++)
            begin
                rem_reg[k] <= ge[k] ? diff[k][DEN_W-1:0] : cat[k][DEN_W-1:0];
                num_reg[k] <= num_in[k] << 1;
                quo_reg[k] <= {quo_in[k][DIV_BITS-2:0], ge[k]};
                den_reg[k] <= den_in[k];
                neg_reg[k] <= neg_in[k];
            end
            out_reg <= out_next;
        end
    end

    // Round toward minus infinity for a negative quotient
    always_comb
    begin
        qext = {2'b00, quo_reg[DIV_BITS-1]};
        if (!neg_reg[DIV_BITS-1])
        begin
            out_next = $signed(qext);
        end
        else if (|rem_reg[DIV_BITS-1])
        begin
            out_next = $signed(~qext);
        end
        else
        begin
            out_next = $signed(-qext);
        end
    end

    assign quo = out_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ray_oriented_box_intersect.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Ray against oriented box, slab test in fixed point.
// Configuration: write the right, up and look rows and the box centre through
// cfg_we / cfg_index / cfg_data while no item is in flight; each write lands
// at once. Squared row lengths settle via registered squares and sums.
// Ray channel: ray_valid / ray_ready carry one origin and direction per item.
// Result channel: res_valid / res_ready carry the hit flag and the entry
// distance (unsigned Q16.16, all ones when too far, zero on a miss).
// Throughput: one item per cycle while the result channel is not stalled;
// the figure is set by the six 52-stage pipelined dividers that form
// the slab limits, one quotient bit per stage.
// Stall: when res_valid is high and res_ready low, the whole pipeline holds
// and ray_ready drops in the same cycle; nothing is lost or repeated.
// Reset: all valid bits clear, the rows return to RIGHT_RESET, UP_RESET
// and LOOK_RESET and the centre to the origin.
module ray_oriented_box_intersect (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             ray_valid,
    output logic                                  ray_ready,
    input  wire roi_pkg::roi_in_t                 ray,
    output logic                                  res_valid,
    input  wire logic                             res_ready,
    output roi_pkg::roi_out_t                     res,
    input  wire logic                             cfg_we,
    input  wire logic [roi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [roi_pkg::CFG_W-1:0]        cfg_data
);
    import roi_pkg::*;

    logic en;
    roi_cfg_t cfg_reg;

    logic front_valid;
    roi_axis_t [2:0] axis;

    logic signed [T_W-1:0] t1 [3];
    logic signed [T_W-1:0] t2 [3];

    logic dvalid_reg [DIV_LAT];
    roi_side_t side_reg [DIV_LAT];
    roi_side_t side_next;

    logic vx_reg;
    roi_side_t sx_reg;
    logic signed [T_W-1:0] lo_reg [3];
    logic signed [T_W-1:0] hi_reg [3];

    logic vy_reg;
    logic signed [T_W-1:0] tmin_reg;
    logic signed [T_W-1:0] tmax_reg;
    logic bounded_reg;
    logic ok_reg;

    logic signed [T_W-1:0] tmin_next;
    logic signed [T_W-1:0] tmax_next;
    logic bounded_next;

    logic res_valid_reg;
    roi_out_t res_reg;
    roi_out_t res_next;
    logic hit_next;

    logic [71:0] sq72 [3];
    logic [71:0] prod [3];
    logic [71:0] thr [3];

    // Hold everything while a finished item waits
    assign en = !res_valid_reg || res_ready;
    assign ray_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.right <= RIGHT_RESET;
            cfg_reg.up <= UP_RESET;
            cfg_reg.look <= LOOK_RESET;
            cfg_reg.pos <= POS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_RIGHT: cfg_reg.right <= cfg_data;
                CFG_UP:    cfg_reg.up <= cfg_data;
                CFG_LOOK:  cfg_reg.look <= cfg_data;
                CFG_POS:   cfg_reg.pos <= cfg_data;
                default:   cfg_reg <= cfg_reg;
            endcase
        end
    end

    roi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ray_valid),
        .in_item   (ray),
        .cfg       (cfg_reg),
        .out_valid (front_valid),
        .axis      (axis)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_axis
        roi_div u_div1 (
            .clk (clk),
            .en  (en),
            .num (axis[i].num1),
            .neg (axis[i].neg1),
            .den (axis[i].den),
            .quo (t1[i])
        );
        roi_div u_div2 (
            .clk (clk),
            .en  (en),
            .num (axis[i].num2),
            .neg (axis[i].neg2),
            .den (axis[i].den),
            .quo (t2[i])
        );
    end

    // Parallel test: 100 * Rd^2 against S scaled by the fraction bits
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq72[i] = {8'd0, axis[i].sq};
            prod[i] = (sq72[i] << 6) + (sq72[i] << 5) + (sq72[i] << 2);
            thr[i] = {40'd0, axis[i].s} << (2 * COORD_FRAC_BITS);
            side_next.use_t[i] = prod[i] > thr[i];
            side_next.ok[i] = side_next.use_t[i] || !axis[i].fail;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_LAT; k++)
            begin
                dvalid_reg[k] <= 1'b0;
            end
            vx_reg <= 1'b0;
            vy_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            dvalid_reg[0] <= front_valid;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                dvalid_reg[k] <= dvalid_reg[k-1];
            end
            vx_reg <= dvalid_reg[DIV_LAT-1];
            vy_reg <= vx_reg;
            res_valid_reg <= vy_reg;
        end
    end

    always_comb
    begin
        tmin_next = '0;
        tmax_next = '0;
        bounded_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (sx_reg.use_t[i])
            begin
                if (lo_reg[i] > tmin_next)
                begin
                    tmin_next = lo_reg[i];
                end
                if (!bounded_next || hi_reg[i] < tmax_next)
                begin
                    tmax_next = hi_reg[i];
                end
                bounded_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        hit_next = ok_reg && (!bounded_reg || tmin_reg <= tmax_reg);
        res_next.hit = hit_next;
        if (!hit_next)
        begin
            res_next.hit_distance = '0;
        end
        else if (tmin_reg > $signed(T_W'(33'h0_FFFF_FFFF)))
        begin
            res_next.hit_distance = '1;
        end
        else
        begin
            res_next.hit_distance = tmin_reg[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            // Order each slab's limits
            for (int i = 0; i < 3; i++)
            begin
                lo_reg[i] <= (t1[i] > t2[i]) ? t2[i] : t1[i];
                hi_reg[i] <= (t1[i] > t2[i]) ? t1[i] : t2[i];
            end
            sx_reg <= side_reg[DIV_LAT-1];
            tmin_reg <= tmin_next;
            tmax_reg <= tmax_next;
            bounded_reg <= bounded_next;
            ok_reg <= &sx_reg.ok;
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res = res_reg;

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.hit |-> res.hit_distance == 32'd0)
        else $error("miss with nonzero distance");

    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        ray_ready == (!res_valid || res_ready))
        else $error("ray_ready out of step with result stall");

    a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dvalid_reg[DIV_LAT-1] && !ray_ready |=> dvalid_reg[DIV_LAT-1])
        else $error("item dropped at divider exit during stall");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vy_reg && !en |=> vy_reg && res_valid)
        else $error("stage before output lost an item during stall");

endmodule

`default_nettype wire

// ----- tb/sv/ray_oriented_box_intersect_tb.sv -----
`timescale 1ns / 1ps

module ray_oriented_box_intersect_tb;
    import roi_pkg::*;

    localparam int IDLE_MAX = 12;
    localparam int LONG_HOLD = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 80;

    class ray_box_scoreboard;
        logic [CFG_W-1:0] rows [4];
        roi_out_t expected_hits [$];
        int mismatches;

        function new();
            rows[CFG_RIGHT] = RIGHT_RESET;
            rows[CFG_UP] = UP_RESET;
            rows[CFG_LOOK] = LOOK_RESET;
            rows[CFG_POS] = POS_RESET;
            mismatches = 0;
        endfunction

        function void set_row(cfg_idx_t idx, logic [CFG_W-1:0] value);
            rows[idx] = value;
        endfunction

        function longint component(logic [CFG_W-1:0] r, int k);
            logic signed [15:0] c;
            c = r[16*k +: 16];
            return longint'(c);
        endfunction

        // Round toward minus infinity to Q.16
        function longint floor_q16(longint num, longint den);
            longint n;
            longint q;
            n = num * 65536;
            q = n / den;
            if (n % den != 0 && n < 0)
                q = q - 1;
            return q;
        endfunction

        function roi_out_t slab_predict(roi_in_t x);
            roi_out_t o;
            longint p [3];
            longint d [3];
            longint r, rp, rd, tmin, tmax, n1, n2, den, t1, t2, tt;
            logic [63:0] s, ard, arp;
            logic [127:0] lhs, rhs;
            bit bounded;
            p[0] = component(rows[CFG_POS], 0) - longint'(x.ray_origin_x);
            p[1] = component(rows[CFG_POS], 1) - longint'(x.ray_origin_y);
            p[2] = component(rows[CFG_POS], 2) - longint'(x.ray_origin_z);
            d[0] = longint'(x.ray_dir_x);
            d[1] = longint'(x.ray_dir_y);
            d[2] = longint'(x.ray_dir_z);
            o = '0;
            tmin = 0;
            tmax = 0;
            bounded = 0;
            for (int i = 0; i < 3; i++)
            begin
                s = 0;
                rp = 0;
                rd = 0;
                for (int k = 0; k < 3; k++)
                begin
                    r = component(rows[i], k);
                    s = s + 64'(r * r);
                    rp = rp + r * p[k];
                    rd = rd + r * d[k];
                end
                ard = (rd < 0) ? 64'(-rd) : 64'(rd);
                lhs = {64'd0, ard} * {64'd0, ard} * 128'd100;
                rhs = {64'd0, s} << (2 * COORD_FRAC_BITS);
                if (lhs > rhs)
                begin
                    n1 = 2 * rp + longint'(s);
                    n2 = 2 * rp - longint'(s);
                    den = 2 * rd;
                    if (den < 0)
                    begin
                        n1 = -n1;
                        n2 = -n2;
                        den = -den;
                    end
                    t1 = floor_q16(n1, den);
                    t2 = floor_q16(n2, den);
                    if (t1 > t2)
                    begin
                        tt = t1;
                        t1 = t2;
                        t2 = tt;
                    end
                    if (t1 > tmin)
                        tmin = t1;
                    if (!bounded || t2 < tmax)
                    begin
                        tmax = t2;
                        bounded = 1;
                    end
                    if (tmin > tmax)
                        return o;
                end
                else
                begin
                    arp = (rp < 0) ? 64'(-rp) : 64'(rp);
                    if (2 * arp > s)
                        return o;
                end
            end
            o.hit = 1'b1;
            o.hit_distance = (tmin > longint'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : tmin[31:0];
            return o;
        endfunction

        function void note_ray(roi_in_t x);
            expected_hits.push_back(slab_predict(x));
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("mismatch %s: got %0d, expected %0d", what, got, want);
            mismatches++;
        endtask

        task check_result(roi_out_t got);
            roi_out_t want;
            if (expected_hits.size() == 0)
            begin
                report_mismatch("unexpected result, hit", got.hit, 0);
                return;
            end
            want = expected_hits.pop_front();
            if (got.hit !== want.hit)
                report_mismatch("hit", got.hit, want.hit);
            if (got.hit_distance !== want.hit_distance)
                report_mismatch("hit_distance", got.hit_distance, want.hit_distance);
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic ray_valid;
    logic ray_ready;
    roi_in_t ray;
    logic res_valid;
    logic res_ready;
    roi_out_t res;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    ray_box_scoreboard sb;
    bit sender_busy_free;
    bit receiver_stalls;
    bit long_hold_req;
    int idle_cycles;

    ray_oriented_box_intersect i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .ray_valid(ray_valid),
        .ray_ready(ray_ready),
        .ray(ray),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res(res),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Receiver: random stall per item, plus one long hold on request
    initial
    begin : receiver
        int wait_n;
        bit acc;
        wait_n = 0;
        res_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            acc = res_valid && res_ready;
            if (acc)
            begin
                sb.check_result(res);
                wait_n = receiver_stalls ? $urandom_range(0, IDLE_MAX) : 0;
            end
            else if (wait_n > 0)
                wait_n--;
            if (long_hold_req)
            begin
                wait_n = LONG_HOLD;
                long_hold_req = 0;
            end
            if (rst_n)
                res_ready <= (wait_n == 0);
        end
    end

    // Watchdog: count cycles with no item moving on either channel
    initial
    begin : watchdog
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((ray_valid && ray_ready) || (res_valid && res_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic send_ray(roi_in_t x);
        int gap;
        gap = sender_busy_free ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap > 0)
        begin
            ray_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ray_valid <= 1'b1;
        ray <= x;
        do
            @(posedge clk);
        while (!(ray_valid && ray_ready));
        sb.note_ray(x);
    endtask

    task automatic drain();
        ray_valid <= 1'b0;
        while (sb.expected_hits.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_row(cfg_idx_t idx, logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        sb.set_row(idx, value);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_box(logic [CFG_W-1:0] r, logic [CFG_W-1:0] u,
                            logic [CFG_W-1:0] l, logic [CFG_W-1:0] c);
        write_row(CFG_RIGHT, r);
        write_row(CFG_UP, u);
        write_row(CFG_LOOK, l);
        write_row(CFG_POS, c);
        // let the squared lengths settle
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [CFG_W-1:0] pack3(int x, int y, int z);
        logic [15:0] a, b, c;
        a = x[15:0];
        b = y[15:0];
        c = z[15:0];
        return {c, b, a};
    endfunction

    function automatic roi_in_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz);
        roi_in_t x;
        x.ray_origin_x = ox[15:0];
        x.ray_origin_y = oy[15:0];
        x.ray_origin_z = oz[15:0];
        x.ray_dir_x = dx[15:0];
        x.ray_dir_y = dy[15:0];
        x.ray_dir_z = dz[15:0];
        return x;
    endfunction

    function automatic int srand(int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    // Mostly rays aimed near the centre; the rest short, zero or raw noise
    function automatic roi_in_t random_ray();
        logic [CFG_W-1:0] c;
        int cx, cy, cz, ox, oy, oz, sel;
        roi_in_t x;
        c = sb.rows[CFG_POS];
        cx = int'($signed(c[15:0]));
        cy = int'($signed(c[31:16]));
        cz = int'($signed(c[47:32]));
        sel = $urandom_range(0, 99);
        if (sel < 60)
        begin
            ox = cx + srand(2048);
            oy = cy + srand(2048);
            oz = cz + srand(2048);
            return make_ray(ox, oy, oz, cx - ox + srand(256), cy - oy + srand(256),
                            cz - oz + srand(256));
        end
        if (sel < 70)
            return make_ray(cx + srand(300), cy + srand(300), cz + srand(300),
                            srand(3), srand(3), srand(3));
        x = {$urandom, $urandom, $urandom};
        return x;
    endfunction

    task automatic random_phase(int n);
        sender_busy_free = ($urandom_range(0, 3) == 0);
        receiver_stalls = ($urandom_range(0, 3) != 0);
        repeat (n) send_ray(random_ray());
        drain();
    endtask

    initial
    begin : main
        roi_in_t directed [$];
        sb = new();
        rst_n = 1'b0;
        ray_valid = 1'b0;
        ray = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_RIGHT;
        cfg_data = '0;
        sender_busy_free = 0;
        receiver_stalls = 1;
        long_hold_req = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset box: the reset rows, centred on the origin
        directed.push_back(make_ray(0, 0, 0, 0, 0, 0));
        directed.push_back(make_ray(1000, 0, 0, 0, 0, 0));
        directed.push_back(make_ray(-1024, 0, 0, 256, 0, 0));
        directed.push_back(make_ray(0, -1024, 0, 0, 256, 0));
        directed.push_back(make_ray(0, 0, -1024, 0, 0, 256));
        directed.push_back(make_ray(0, 0, 1024, 0, 0, -256));
        directed.push_back(make_ray(-1024, 0, 0, -256, 0, 0));
        directed.push_back(make_ray(-1024, 2000, 0, 256, 0, 0));
        directed.push_back(make_ray(32767, 32767, 32767, -32768, -32768, -32768));
        directed.push_back(make_ray(-32768, -32768, -32768, 32767, 32767, 32767));
        directed.push_back(make_ray(-32768, 0, 0, 1, 0, 0));
        directed.push_back(make_ray(-32768, 0, 0, 32767, 0, 0));
        directed.push_back(make_ray(0, 0, 0, 32767, -32768, 1));
        directed.push_back(make_ray(-1024, 0, 0, 256, 25, 0));
        directed.push_back(make_ray(-1024, 0, 0, 256, 26, 0));
        directed.push_back(make_ray(0, 128, 0, 0, 0, 0));
        directed.push_back(make_ray(0, 129, 0, 0, 0, 0));
        directed.push_back(make_ray(-1024, -1024, 0, 256, 256, 0));
        directed.push_back(make_ray(-1024, 1024, 0, 256, 256, 0));
        foreach (directed[i])
            send_ray(directed[i]);
        drain();

        // axis-aligned box off the origin, one zero-length row
        load_box(pack3(512, 0, 0), pack3(0, 256, 0), pack3(0, 0, 0), pack3(128, -256, 512));
        send_ray(make_ray(128, -256, 512, 0, 0, 0));
        send_ray(make_ray(-2000, -256, 512, 256, 0, 0));
        send_ray(make_ray(128, -256, 30000, 0, 0, -1));
        random_phase(150);

        // extreme rows
        load_box(pack3(32767, 32767, 32767), pack3(-32768, -32768, -32768),
                 pack3(0, 0, 0), pack3(32767, -32768, 0));
        send_ray(make_ray(32767, -32768, 0, 0, 0, 0));
        send_ray(make_ray(-32768, 32767, -32768, 32767, -32768, 32767));
        random_phase(120);

        load_box(pack3(-32768, 0, 0), pack3(0, 32767, 0), pack3(0, 0, -32768), pack3(0, 0, 0));
        random_phase(120);

        // long receiver hold with the sender running flat out
        load_box(pack3(256, 0, 0), pack3(0, 256, 0), pack3(0, 0, 256), pack3(0, 0, 0));
        sender_busy_free = 1;
        receiver_stalls = 0;
        long_hold_req = 1;
        repeat (150) send_ray(random_ray());
        drain();

        repeat (5)
        begin
            load_box(pack3(srand(1024), srand(1024), srand(1024)),
                     pack3(srand(1024), srand(1024), srand(1024)),
                     pack3(srand(1024), srand(1024), srand(1024)),
                     pack3(srand(2048), srand(2048), srand(2048)));
            random_phase(150);
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_hits.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
